FILE: design/mono_lcd_framebuffer_dirty_flush_top_macros.svh
// assertion macros for the framebuffer flush block
`ifndef MONO_LCD_FRAMEBUFFER_DIRTY_FLUSH_TOP_MACROS_SVH
`define MONO_LCD_FRAMEBUFFER_DIRTY_FLUSH_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define MLFD_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define MLFD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: design/mlfd_pkg.sv
// shared types and constants of the framebuffer flush block
package mlfd_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 84;
    localparam int DISPLAY_HEIGHT_DEF = 48;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int BAND_W = 3;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam logic REPLY_PIXEL = 1'b0;
    localparam logic REPLY_BUS   = 1'b1;

    localparam logic [7:0] CMD_BAND   = 8'h40;
    localparam logic [7:0] CMD_COLUMN = 8'h80;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BAND_CMD,
        PH_COL_CMD,
        PH_DATA,
        PH_END
    } flush_phase_t;

endpackage

FILE: design/mono_lcd_framebuffer_dirty_flush_top.sv
// top level of the 1-bit framebuffer with dirty-rectangle flush
// A 1-bit framebuffer for a small monochrome display, kept in one synchronous
// memory of DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT/8) bytes, each byte holding 8
// vertical pixels of one 8-row band. Items on the slave stream set a pixel,
// read a pixel or ask for the next byte of the flush sequence; a flush walks
// every dirty band (band command, column command, then the dirty columns'
// data bytes) and closes with a band command flagged by tlast. After reset the
// memory is swept to zero, one byte per cycle, and no item is taken meanwhile.
// Each item is then accepted in idle, where the memory read is issued, and
// moves to execute, which uses the registered read data for the modify,
// write-back and result. With a single memory port pair and a registered
// read, the block takes no new item until the current one has left execute.
// Only one item is in the memory loop at a time, so a read never meets a
// pending write to the same byte. The result sits in an output register; a
// new item is accepted while it waits, but that item then holds in execute,
// whether it makes a result or not, until the waiting result has been taken.
`include "mono_lcd_framebuffer_dirty_flush_top_macros.svh"

module mono_lcd_framebuffer_dirty_flush_top #(
    parameter int DISPLAY_WIDTH  = mlfd_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = mlfd_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // column[6:0], row[12:7], color[13], zero[15:14]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_value[0], bus_byte[8:1], data_mode[9], zero[15:10]
    output logic        m_tuser,   // reply_kind[0]
    output logic        m_tlast    // transfer_end
);

    localparam int BandCount  = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FrameBytes = DISPLAY_WIDTH * BandCount;
    localparam int AddrW      = $clog2(FrameBytes);
    localparam int ColW       = mlfd_pkg::COL_W;
    localparam int RowW       = mlfd_pkg::ROW_W;
    localparam int BandW      = mlfd_pkg::BAND_W;

    localparam logic [AddrW-1:0] LastAddr  = AddrW'(FrameBytes - 1);
    localparam logic [ColW:0]    WidthVal  = (ColW + 1)'(DISPLAY_WIDTH);
    localparam logic [RowW:0]    HeightVal = (RowW + 1)'(DISPLAY_HEIGHT);

    // byte address of a column within a band
    function automatic logic [AddrW-1:0] byte_addr(input logic [ColW-1:0] col,
                                                   input logic [BandW-1:0] band);
        logic [31:0] full;
        full = 32'(col) + 32'(band) * 32'(DISPLAY_WIDTH);
        return full[AddrW-1:0];
    endfunction

    // input fields
    logic [ColW-1:0]   in_column;
    logic [RowW-1:0]   in_row;
    logic              in_color;
    assign in_column = s_tdata[6:0];
    assign in_row    = s_tdata[12:7];
    assign in_color  = s_tdata[13];

    // control state
    mlfd_pkg::ctrl_state_t state_reg, state_next;
    logic [AddrW-1:0]      clr_addr_reg, clr_addr_next;

    // captured item
    logic [1:0]      kind_reg;
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic            color_reg;
    logic            inside_reg;

    // dirty rectangle, one extra bit so the empty marks fit
    logic [ColW:0] dirty_left_reg, dirty_left_next;
    logic [RowW:0] dirty_top_reg, dirty_top_next;
    logic [ColW:0] dirty_right_reg, dirty_right_next;
    logic [RowW:0] dirty_bottom_reg, dirty_bottom_next;

    // flush sequencer
    mlfd_pkg::flush_phase_t flush_phase_reg, flush_phase_next;
    logic [BandW-1:0] flush_band_reg, flush_band_next;
    logic [ColW-1:0]  flush_column_reg, flush_column_next;
    logic [ColW-1:0]  latched_left_reg, latched_left_next;
    logic [ColW-1:0]  latched_right_reg, latched_right_next;
    logic [BandW-1:0] latched_last_band_reg, latched_last_band_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_kind_reg;
    logic       out_pixel_reg;
    logic [7:0] out_byte_reg;
    logic       out_dm_reg;
    logic       out_end_reg;

    // memory
    logic [7:0]       mem [FrameBytes];
    logic [7:0]       mem_rdata_reg;
    logic             mem_re;
    logic [AddrW-1:0] mem_raddr;
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [7:0]       mem_wdata;

    // exec stage signals
    logic             accept;
    logic             out_free;
    logic             commit;
    logic             set_we;
    logic [7:0]       set_wdata;
    logic [7:0]       bit_mask;
    logic             res_valid;
    logic             res_kind;
    logic             res_pixel;
    logic [7:0]       res_byte;
    logic             res_dm;
    logic             res_end;
    logic             in_inside;

    assign out_free = !out_valid_reg || m_tready;

    // ---------------- control state machine ----------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            mlfd_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AddrW'(1);
                if (clr_addr_reg == LastAddr)
                begin
                    state_next = mlfd_pkg::ST_IDLE;
                end
            end
            mlfd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mlfd_pkg::ST_EXEC;
                end
            end
            mlfd_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = mlfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mlfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            mlfd_pkg::ST_CLEAR: s_tready = 1'b0;
            mlfd_pkg::ST_IDLE:  s_tready = 1'b1;
            mlfd_pkg::ST_EXEC:  commit   = out_free;
            default:            s_tready = 1'b0;
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign in_inside = ({1'b0, in_column} < WidthVal) && ({1'b0, in_row} < HeightVal);

    // read address: pixel items use their own coordinates, ticks the flush cursor
    assign mem_re    = accept;
    assign mem_raddr = (s_tuser == mlfd_pkg::KIND_TICK)
                     ? byte_addr(flush_column_reg, flush_band_reg)
                     : byte_addr(in_column, in_row[RowW-1:3]);

    // ---------------- exec stage ----------------
    assign bit_mask  = 8'(1) << row_reg[2:0];
    assign set_wdata = color_reg ? (mem_rdata_reg | bit_mask) : (mem_rdata_reg & ~bit_mask);

    always_comb
    begin
        dirty_left_next        = dirty_left_reg;
        dirty_top_next         = dirty_top_reg;
        dirty_right_next       = dirty_right_reg;
        dirty_bottom_next      = dirty_bottom_reg;
        flush_phase_next       = flush_phase_reg;
        flush_band_next        = flush_band_reg;
        flush_column_next      = flush_column_reg;
        latched_left_next      = latched_left_reg;
        latched_right_next     = latched_right_reg;
        latched_last_band_next = latched_last_band_reg;
        set_we                 = 1'b0;
        res_valid              = 1'b0;
        res_kind               = mlfd_pkg::REPLY_BUS;
        res_pixel              = 1'b0;
        res_byte               = 8'd0;
        res_dm                 = 1'b0;
        res_end                = 1'b0;
        if (commit)
        begin
            case (kind_reg)
                mlfd_pkg::KIND_SET:
                begin
                    if (inside_reg)
                    begin
                        set_we = 1'b1;
                        if ({1'b0, col_reg} < dirty_left_reg)
                            dirty_left_next = {1'b0, col_reg};
                        if ({1'b0, row_reg} < dirty_top_reg)
                            dirty_top_next = {1'b0, row_reg};
                        if ({1'b0, col_reg} > dirty_right_reg)
                            dirty_right_next = {1'b0, col_reg};
                        if ({1'b0, row_reg} > dirty_bottom_reg)
                            dirty_bottom_next = {1'b0, row_reg};
                    end
                end
                mlfd_pkg::KIND_READ:
                begin
                    res_valid = 1'b1;
                    res_kind  = mlfd_pkg::REPLY_PIXEL;
                    res_pixel = inside_reg && mem_rdata_reg[row_reg[2:0]];
                end
                mlfd_pkg::KIND_TICK:
                begin
                    unique case (flush_phase_reg)
                        mlfd_pkg::PH_IDLE:
                        begin
                            // start only with a non-empty rectangle
                            if ((dirty_left_reg <= dirty_right_reg)
                                && (dirty_top_reg <= dirty_bottom_reg))
                            begin
                                latched_left_next      = dirty_left_reg[ColW-1:0];
                                latched_right_next     = dirty_right_reg[ColW-1:0];
                                flush_band_next        = dirty_top_reg[RowW-1:3];
                                latched_last_band_next = dirty_bottom_reg[RowW-1:3];
                                dirty_left_next        = WidthVal;
                                dirty_top_next         = HeightVal;
                                dirty_right_next       = '0;
                                dirty_bottom_next      = '0;
                                flush_phase_next       = mlfd_pkg::PH_COL_CMD;
                                res_valid              = 1'b1;
                                res_byte = mlfd_pkg::CMD_BAND | 8'(dirty_top_reg[RowW-1:3]);
                            end
                        end
                        mlfd_pkg::PH_BAND_CMD:
                        begin
                            flush_phase_next = mlfd_pkg::PH_COL_CMD;
                            res_valid        = 1'b1;
                            res_byte         = mlfd_pkg::CMD_BAND | 8'(flush_band_reg);
                        end
                        mlfd_pkg::PH_COL_CMD:
                        begin
                            flush_column_next = latched_left_reg;
                            flush_phase_next  = mlfd_pkg::PH_DATA;
                            res_valid         = 1'b1;
                            res_byte          = mlfd_pkg::CMD_COLUMN | 8'(latched_left_reg);
                        end
                        mlfd_pkg::PH_DATA:
                        begin
                            if (flush_column_reg >= latched_right_reg)
                            begin
                                if (flush_band_reg >= latched_last_band_reg)
                                begin
                                    flush_phase_next = mlfd_pkg::PH_END;
                                end
                                else
                                begin
                                    flush_band_next  = flush_band_reg + BandW'(1);
                                    flush_phase_next = mlfd_pkg::PH_BAND_CMD;
                                end
                            end
                            else
                            begin
                                flush_column_next = flush_column_reg + ColW'(1);
                            end
                            res_valid = 1'b1;
                            res_byte  = mem_rdata_reg;
                            res_dm    = 1'b1;
                        end
                        mlfd_pkg::PH_END:
                        begin
                            flush_phase_next = mlfd_pkg::PH_IDLE;
                            res_valid        = 1'b1;
                            res_byte         = mlfd_pkg::CMD_BAND;
                            res_end          = 1'b1;
                        end
                        default:
                        begin
                            flush_phase_next = mlfd_pkg::PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // write port: clearing sweep after reset, otherwise the set-pixel write-back
    assign mem_we    = (state_reg == mlfd_pkg::ST_CLEAR) || set_we;
    assign mem_waddr = (state_reg == mlfd_pkg::ST_CLEAR) ? clr_addr_reg
                                                         : byte_addr(col_reg, row_reg[RowW-1:3]);
    assign mem_wdata = (state_reg == mlfd_pkg::ST_CLEAR) ? 8'd0 : set_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tuser;
            col_reg    <= in_column;
            row_reg    <= in_row;
            color_reg  <= in_color;
            inside_reg <= in_inside;
        end
    end

    assign out_valid_next = res_valid || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= mlfd_pkg::ST_CLEAR;
            clr_addr_reg          <= '0;
            dirty_left_reg        <= WidthVal;
            dirty_top_reg         <= HeightVal;
            dirty_right_reg       <= '0;
            dirty_bottom_reg      <= '0;
            flush_phase_reg       <= mlfd_pkg::PH_IDLE;
            flush_band_reg        <= '0;
            flush_column_reg      <= '0;
            latched_left_reg      <= '0;
            latched_right_reg     <= '0;
            latched_last_band_reg <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg             <= state_next;
            clr_addr_reg          <= clr_addr_next;
            dirty_left_reg        <= dirty_left_next;
            dirty_top_reg         <= dirty_top_next;
            dirty_right_reg       <= dirty_right_next;
            dirty_bottom_reg      <= dirty_bottom_next;
            flush_phase_reg       <= flush_phase_next;
            flush_band_reg        <= flush_band_next;
            flush_column_reg      <= flush_column_next;
            latched_left_reg      <= latched_left_next;
            latched_right_reg     <= latched_right_next;
            latched_last_band_reg <= latched_last_band_next;
            out_valid_reg         <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_kind_reg  <= res_kind;
            out_pixel_reg <= res_pixel;
            out_byte_reg  <= res_byte;
            out_dm_reg    <= res_dm;
            out_end_reg   <= res_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_dm_reg, out_byte_reg, out_pixel_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_end_reg;

    // ---------------- assertions ----------------
    `MLFD_ASSERT_NEXT(a_accept_then_exec, accept,
        (state_reg == mlfd_pkg::ST_EXEC) && !s_tready,
        "accepted item did not move to execute")
    `MLFD_ASSERT_NOW(a_cursor_in_rect, (flush_phase_reg == mlfd_pkg::PH_DATA),
        (flush_column_reg <= latched_right_reg) && (flush_band_reg <= latched_last_band_reg),
        "flush cursor left the latched rectangle")
    `MLFD_ASSERT_NOW(a_end_byte, m_tvalid && m_tlast,
        (m_tdata[8:1] == mlfd_pkg::CMD_BAND) && m_tuser && !m_tdata[9],
        "transfer end not on closing band command")

endmodule

FILE: tb/sv/mlfd_flush_checker.sv
// checker for the framebuffer flush block: mirrors the framebuffer and compares every result item
module mlfd_flush_checker
    import mlfd_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // column[6:0], row[12:7], color[13], zero[15:14]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // pixel_value[0], bus_byte[8:1], data_mode[9], zero[15:10]
    input  logic        m_tuser,   // reply_kind[0]
    input  logic        m_tlast,   // transfer_end
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANDS       = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = DISPLAY_WIDTH * BANDS;

    typedef struct packed {
        logic       reply_kind;
        logic       pixel_value;
        logic [7:0] bus_byte;
        logic       data_mode;
        logic       transfer_end;
    } reply_t;

    reply_t             expected_replies[$];
    logic [7:0]         frame [FRAME_BYTES];
    logic [COL_W-1:0]   dirty_left, dirty_right;
    logic [ROW_W-1:0]   dirty_top, dirty_bottom;
    flush_phase_t       phase;
    logic [BAND_W-1:0]  flush_band, last_band;
    logic [COL_W-1:0]   flush_col, held_left, held_right;
    int                 errs = 0;

    function automatic int byte_addr(int col, int band);
        int a;
        a = col + band * DISPLAY_WIDTH;
        return (a < FRAME_BYTES) ? a : 0;
    endfunction

    function automatic reply_t bus_reply(logic [7:0] value, logic dm, logic last);
        reply_t r;
        r              = '0;
        r.reply_kind   = REPLY_BUS;
        r.bus_byte     = value;
        r.data_mode    = dm;
        r.transfer_end = last;
        return r;
    endfunction

    task automatic clear_frame();
        for (int i = 0; i < FRAME_BYTES; i++)
            frame[i] = '0;
        dirty_left   = COL_W'(DISPLAY_WIDTH);
        dirty_top    = ROW_W'(DISPLAY_HEIGHT);
        dirty_right  = '0;
        dirty_bottom = '0;
        phase        = PH_IDLE;
        flush_band   = '0;
        flush_col    = '0;
        held_left    = '0;
        held_right   = '0;
        last_band    = '0;
    endtask

    // advance the mirrored framebuffer by one item and queue what it returns
    task automatic apply_item(logic [KIND_W-1:0] kind, logic [COL_W-1:0] col,
                              logic [ROW_W-1:0] row, logic color);
        bit         on_screen;
        int         a;
        logic [7:0] value;
        reply_t     r;
        on_screen = (col < DISPLAY_WIDTH) && (row < DISPLAY_HEIGHT);
        a         = byte_addr(col, row >> 3);
        case (kind)
            KIND_SET:
                if (on_screen)
                begin
                    frame[a][row[2:0]] = color;
                    if (col < dirty_left)   dirty_left   = col;
                    if (row < dirty_top)    dirty_top    = row;
                    if (col > dirty_right)  dirty_right  = col;
                    if (row > dirty_bottom) dirty_bottom = row;
                end
            KIND_READ:
            begin
                r            = '0;
                r.reply_kind = REPLY_PIXEL;
                if (on_screen)
                    r.pixel_value = frame[a][row[2:0]];
                expected_replies.push_back(r);
            end
            KIND_TICK:
                case (phase)
                    PH_IDLE:
                        // nothing dirty means nothing to send
                        if (dirty_left <= dirty_right && dirty_top <= dirty_bottom)
                        begin
                            held_left    = dirty_left;
                            held_right   = dirty_right;
                            flush_band   = BAND_W'(dirty_top >> 3);
                            last_band    = BAND_W'(dirty_bottom >> 3);
                            dirty_left   = COL_W'(DISPLAY_WIDTH);
                            dirty_top    = ROW_W'(DISPLAY_HEIGHT);
                            dirty_right  = '0;
                            dirty_bottom = '0;
                            phase        = PH_COL_CMD;
                            expected_replies.push_back(
                                bus_reply(CMD_BAND | 8'(flush_band), 1'b0, 1'b0));
                        end
                    PH_BAND_CMD:
                    begin
                        phase = PH_COL_CMD;
                        expected_replies.push_back(
                            bus_reply(CMD_BAND | 8'(flush_band), 1'b0, 1'b0));
                    end
                    PH_COL_CMD:
                    begin
                        flush_col = held_left;
                        phase     = PH_DATA;
                        expected_replies.push_back(
                            bus_reply(CMD_COLUMN | 8'(held_left), 1'b0, 1'b0));
                    end
                    PH_DATA:
                    begin
                        // data is taken from memory at the tick that sends it
                        value = frame[byte_addr(flush_col, flush_band)];
                        if (flush_col >= held_right)
                        begin
                            if (flush_band >= last_band)
                                phase = PH_END;
                            else
                            begin
                                flush_band = flush_band + 1'b1;
                                phase      = PH_BAND_CMD;
                            end
                        end
                        else
                            flush_col = flush_col + 1'b1;
                        expected_replies.push_back(bus_reply(value, 1'b1, 1'b0));
                    end
                    default:
                    begin
                        phase = PH_IDLE;
                        expected_replies.push_back(bus_reply(CMD_BAND, 1'b0, 1'b1));
                    end
                endcase
            default: ;
        endcase
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got.reply_kind   = m_tuser;
        got.pixel_value  = m_tdata[0];
        got.bus_byte     = m_tdata[8:1];
        got.data_mode    = m_tdata[9];
        got.transfer_end = m_tlast;
        if (expected_replies.size() == 0)
        begin
            errs++;
            if (errs <= 10)
                $display({"%0t: result with nothing expected: ",
                          "kind %0b pixel %0b byte %02h dc %0b end %0b"},
                         $realtime, got.reply_kind, got.pixel_value, got.bus_byte,
                         got.data_mode, got.transfer_end);
        end
        else
        begin
            want = expected_replies.pop_front();
            if (got !== want)
            begin
                errs++;
                if (errs <= 10)
                    $display({"%0t: result mismatch: expected kind %0b pixel %0b ",
                              "byte %02h dc %0b end %0b, ",
                              "got kind %0b pixel %0b byte %02h dc %0b end %0b"},
                             $realtime, want.reply_kind, want.pixel_value, want.bus_byte,
                             want.data_mode, want.transfer_end, got.reply_kind,
                             got.pixel_value, got.bus_byte, got.data_mode, got.transfer_end);
            end
        end
    endtask

    // results are taken before the new item, so a same-edge pair never matches itself
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            expected_replies.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_reply();
            if (s_tvalid && s_tready)
                apply_item(s_tuser, s_tdata[6:0], s_tdata[12:7], s_tdata[13]);
        end
        pending    <= expected_replies.size();
        fail_count <= errs;
    end

endmodule

FILE: tb/sv/tb_mono_lcd_framebuffer_dirty_flush_top.sv
// testbench top for the framebuffer flush block: stimulus, reset and verdict
module tb_mono_lcd_framebuffer_dirty_flush_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mlfd_pkg::*;

    localparam int                W           = DISPLAY_WIDTH_DEF;
    localparam int                H           = DISPLAY_HEIGHT_DEF;
    localparam int                BAND_COUNT  = H / 8;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                ITEM_TARGET = 950;
    localparam int                IDLE_PCT    = 32;

    // clock and reset
    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    // slave side, driven here
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // column[6:0], row[12:7], color[13], zero[15:14]
    logic [1:0]  s_tuser  = '0;    // kind[1:0]

    // master side, drained here
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // pixel_value[0], bus_byte[8:1], data_mode[9], zero[15:10]
    logic        m_tuser;          // reply_kind[0]
    logic        m_tlast;          // transfer_end

    int fail_count;
    int pending;
    int sent_count = 0;            // items that do something in the block
    bit steady     = 1'b0;         // when set neither side idles

    always #6 clk = ~clk;

    mono_lcd_framebuffer_dirty_flush_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mlfd_flush_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver backpressure, one assignment per edge
    always @(posedge clk)
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

    // hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("mono_lcd_framebuffer_dirty_flush_top regression: fail");
        $finish;
    end

    // one item on the slave side, with random idle cycles in front of it
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic color);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, color, row, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // unused kind and off-screen sets are ignored by the block
        if (kind != KIND_UNUSED && !(kind == KIND_SET && (col >= W || row >= H)))
            sent_count++;
    endtask

    // flush ticks; the position fields are don't-care so they carry random bits
    task automatic tick(input int count);
        repeat (count)
            send_item(KIND_TICK, COL_W'($urandom_range(127)), ROW_W'($urandom_range(63)),
                      1'($urandom_range(1)));
    endtask

    // anything the fields allow, including off-screen and the unused kind
    task automatic noise_item();
        send_item(KIND_W'($urandom_range(3)), COL_W'($urandom_range(127)),
                  ROW_W'($urandom_range(63)), 1'($urandom_range(1)));
    endtask

    // stop sending until every queued result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // draw a few pixels in a small box, then tick through (most of) its flush,
    // sometimes drawing or reading while the flush runs
    task automatic draw_and_flush();
        int w;
        int nb;
        int x0;
        int b0;
        int nticks;
        w  = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        nb = ($urandom_range(99) < 75) ? 1 : $urandom_range(2, 3);
        x0 = $urandom_range(0, W - w);
        b0 = $urandom_range(0, BAND_COUNT - nb);
        repeat ($urandom_range(1, 6))
            send_item(($urandom_range(99) < 25) ? KIND_READ : KIND_SET,
                      COL_W'(x0 + $urandom_range(w - 1)),
                      ROW_W'(b0 * 8 + $urandom_range(nb * 8 - 1)), 1'($urandom_range(1)));
        // band cmd + column cmd + data per band, then the closing command
        nticks = nb * (w + 2) + 1;
        if ($urandom_range(99) < 20)
            nticks = $urandom_range(1, nticks);
        else
            nticks = nticks + $urandom_range(0, 2);
        repeat (nticks)
        begin
            if ($urandom_range(99) < 8)
                send_item(KIND_SET, COL_W'($urandom_range(W - 1)), ROW_W'($urandom_range(H - 1)),
                          1'($urandom_range(1)));
            else if ($urandom_range(99) < 6)
                send_item(KIND_READ, COL_W'($urandom_range(W - 1)),
                          ROW_W'($urandom_range(H - 1)), 1'($urandom_range(1)));
            tick(1);
        end
    endtask

    initial
    begin
        bit paused_mid;
        paused_mid = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty rectangle, unused kind, off-screen accesses
        tick(1);
        send_item(KIND_UNUSED, 7'd0, 6'd0, 1'b1);
        send_item(KIND_READ, 7'd127, 6'd63, 1'b0);
        send_item(KIND_SET, 7'd127, 6'd63, 1'b1);
        send_item(KIND_SET, 7'd84, 6'd0, 1'b1);
        send_item(KIND_SET, 7'd0, 6'd48, 1'b1);
        tick(1);
        send_item(KIND_READ, 7'd84, 6'd0, 1'b0);
        send_item(KIND_READ, 7'd0, 6'd48, 1'b0);
        // small flush with writes landing in the middle of it
        send_item(KIND_SET, 7'd0, 6'd0, 1'b1);
        send_item(KIND_SET, 7'd1, 6'd1, 1'b1);
        send_item(KIND_READ, 7'd0, 6'd0, 1'b0);
        tick(2);                                   // band and column commands
        send_item(KIND_SET, 7'd1, 6'd8, 1'b1);     // next band, goes to the new rectangle
        send_item(KIND_SET, 7'd1, 6'd0, 1'b1);     // shows up in the pending data byte
        tick(3);                                   // two data bytes and the end mark
        send_item(KIND_SET, 7'd0, 6'd0, 1'b0);     // clear a dark pixel
        send_item(KIND_READ, 7'd0, 6'd0, 1'b0);
        send_item(KIND_SET, 7'd83, 6'd47, 1'b1);   // far corner
        send_item(KIND_READ, 7'd83, 6'd47, 1'b0);
        tick(4);
        drain();

        // rectangle edges: full height at column 0, bottom-right corner, full-width band
        send_item(KIND_SET, 7'd0, 6'd47, 1'b1);
        send_item(KIND_SET, 7'd0, 6'd0, 1'b1);
        tick(BAND_COUNT * 3 + 2);
        send_item(KIND_SET, 7'd83, 6'd40, 1'b1);
        send_item(KIND_SET, 7'd80, 6'd47, 1'b1);
        tick(2 + 4 + 2);
        send_item(KIND_SET, 7'd0, 6'd8, 1'b1);
        send_item(KIND_SET, 7'd83, 6'd15, 1'b1);
        tick(2 + W + 2);

        // random part: mostly draw-then-flush rounds, the rest raw noise
        while (sent_count < ITEM_TARGET)
        begin
            steady = (sent_count >= 400 && sent_count < 550);
            if (!paused_mid && sent_count >= 650)
            begin
                drain();
                paused_mid = 1'b1;
            end
            if ($urandom_range(99) < 75)
                draw_and_flush();
            else
                repeat ($urandom_range(1, 4))
                    noise_item();
        end
        steady = 1'b0;

        // wind down: let all results out, then a few spare cycles
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("mono_lcd_framebuffer_dirty_flush_top regression: pass");
        else
            $display("mono_lcd_framebuffer_dirty_flush_top regression: fail");
        $finish;
    end

endmodule
